[rtl/core/slpg_pkg.sv]
// ============================================================================
// slpg_pkg
// Shared widths, constants, register indexes and controller/datapath types
// for the scrolling LED pattern generator.
// ============================================================================
package slpg_pkg;

   // Field widths.
   localparam int IDX_W   = 6;   // LED index
   localparam int CNT_W   = 7;   // LED count, wide enough for 1..64
   localparam int COLOR_W = 8;   // one color channel
   localparam int SEC_W   = 3;   // hue sector, 0..5
   localparam int REM_W   = 6;   // hue remainder within a sector, 0..59

   // Configuration register indexes.
   localparam logic [1:0] REG_LED_COUNT    = 2'd0;
   localparam logic [1:0] REG_PATTERN_MODE = 2'd1;
   localparam logic [1:0] REG_SATURATION   = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [CNT_W-1:0]   LED_COUNT_RST  = 7'd8;
   localparam logic [COLOR_W-1:0] SATURATION_RST = 8'd255;

   // Pattern modes.
   localparam logic MODE_RAINBOW  = 1'b0;
   localparam logic MODE_GRADIENT = 1'b1;

   // Hue arithmetic. A hue is kept as sector and remainder so that no
   // division by 60 is needed on it.
   localparam logic [REM_W-1:0] SECTOR_SPAN = 6'd60;
   localparam logic [REM_W-1:0] HUE_PER_LED = 6'd20;
   localparam logic [REM_W-1:0] HUE_PER_FRM = 6'd5;
   localparam logic [SEC_W-1:0] LAST_SECTOR = 3'd5;

   // floor(x / 60) equals (x * RECIP60) >> 20 for every x up to 255 * 60.
   localparam logic [14:0] RECIP60     = 15'd17477;
   localparam int          RECIP60_SHR = 20;

   // Brightness falls by 35 per LED of distance and is zero beyond three.
   localparam logic [IDX_W-1:0] MAX_DIST = 6'd3;

   function automatic logic [COLOR_W-1:0] bright_of(input logic [1:0] span);
      logic [COLOR_W-1:0] val;
      case (span)
         2'd0:    val = 8'd255;
         2'd1:    val = 8'd220;
         2'd2:    val = 8'd185;
         2'd3:    val = 8'd150;
         default: val = 8'd0;
      endcase
      return val;
   endfunction

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic frame_start;  // load index 0 and the frame's base hue
      logic led_next;     // step to the next LED
      logic out_load;     // capture the current LED's color in the output
      logic frame_end;    // advance the centre and, in rainbow mode, the hue offset
   } slpg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;         // the current LED is the last of the frame
   } slpg_stat_type;

endpackage

[rtl/core/slpg_ctrl.sv]
// ============================================================================
// slpg_ctrl
// Frame sequencer: takes a frame tick, walks each LED through the color
// pipeline and hands every color to the output register.
// ============================================================================
module slpg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  slpg_pkg::slpg_stat_type stat,
   output slpg_pkg::slpg_cmd_type  cmd
);
   import slpg_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL1  = 3'd1;
   localparam logic [2:0] ST_DIV60 = 3'd2;
   localparam logic [2:0] ST_MUL2  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // The output register can take a new color when it is empty or when
   // its current color is being transferred in this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.frame_start = 1'b1;
               state_in        = ST_MUL1;
            end
         end
         ST_MUL1:  state_in = ST_DIV60;
         ST_DIV60: state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_DIV;
         ST_DIV:   state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               if (stat.last) begin
                  cmd.frame_end = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.led_next = 1'b1;
                  state_in     = ST_MUL1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/slpg_dp.sv]
// ============================================================================
// slpg_dp
// Color datapath: LED index and hue stepping, distance brightness, a
// four-stage integer HSV-to-RGB pipeline and the output color register.
// ============================================================================
module slpg_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  slpg_pkg::slpg_cmd_type              cmd,
   output slpg_pkg::slpg_stat_type             stat,
   input  logic                                req_restart,
   input  logic [slpg_pkg::CNT_W-1:0]          led_cnt,
   input  logic                                pattern_mode,
   input  logic [slpg_pkg::COLOR_W-1:0]        saturation,
   output logic [slpg_pkg::IDX_W-1:0]          rsp_led_index,
   output logic [slpg_pkg::COLOR_W-1:0]        rsp_red,
   output logic [slpg_pkg::COLOR_W-1:0]        rsp_green,
   output logic [slpg_pkg::COLOR_W-1:0]        rsp_blue,
   output logic                                rsp_last_led
);
   import slpg_pkg::*;

   // Frame state.
   logic [IDX_W-1:0] centre_ff, centre_in;
   logic [SEC_W-1:0] off_sec_ff, off_sec_in;
   logic [REM_W-1:0] off_rem_ff, off_rem_in;

   // Current LED.
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SEC_W-1:0] hsec_ff, hsec_in;
   logic [REM_W-1:0] hrem_ff, hrem_in;

   logic [REM_W:0]   led_rem_sum, frm_rem_sum;
   logic [IDX_W:0]   centre_inc;

   // Pipeline stages.
   logic [IDX_W-1:0]   led_span;
   logic [COLOR_W-1:0] s1_bright_ff, s2_bright_ff, s3_bright_ff, s4_bright_ff;
   logic [SEC_W-1:0]   s1_sec_ff, s2_sec_ff, s3_sec_ff, s4_sec_ff;
   logic [13:0]        s1_sq_ff, s1_st_ff;
   logic [28:0]        prod_q, prod_t;
   logic [COLOR_W-1:0] s2_dq_ff, s2_dt_ff;
   logic [15:0]        s3_mp_ff, s3_mq_ff, s3_mt_ff;
   logic [16:0]        sum_p, sum_q, sum_t;
   logic [COLOR_W-1:0] s4_p_ff, s4_q_ff, s4_t_ff;

   logic [COLOR_W-1:0] red_in, green_in, blue_in;
   logic [IDX_W-1:0]   led_index_ff;
   logic [COLOR_W-1:0] red_ff, green_ff, blue_ff;
   logic               last_ff;

   assign stat.last = (({1'b0, idx_ff} + 7'd1) == led_cnt);

   // Hue steps, each a wrap within the sector and a wrap over six sectors.
   assign led_rem_sum = {1'b0, hrem_ff} + {1'b0, HUE_PER_LED};
   assign frm_rem_sum = {1'b0, off_rem_ff} + {1'b0, HUE_PER_FRM};
   assign centre_inc  = {1'b0, centre_ff} + 7'd1;

   always_comb begin
      centre_in  = centre_ff;
      off_sec_in = off_sec_ff;
      off_rem_in = off_rem_ff;
      idx_in     = idx_ff;
      hsec_in    = hsec_ff;
      hrem_in    = hrem_ff;
      if (cmd.frame_start) begin
         idx_in = '0;
         if (req_restart) begin
            centre_in  = '0;
            off_sec_in = '0;
            off_rem_in = '0;
            hsec_in    = '0;
            hrem_in    = '0;
         end else begin
            hsec_in = off_sec_ff;
            hrem_in = off_rem_ff;
         end
      end
      if (cmd.led_next) begin
         idx_in = idx_ff + 6'd1;
         if (led_rem_sum >= {1'b0, SECTOR_SPAN}) begin
            hrem_in = REM_W'(led_rem_sum - {1'b0, SECTOR_SPAN});
            hsec_in = (hsec_ff == LAST_SECTOR) ? '0 : hsec_ff + 3'd1;
         end else begin
            hrem_in = led_rem_sum[REM_W-1:0];
         end
      end
      if (cmd.frame_end) begin
         centre_in = (centre_inc >= led_cnt) ? '0 : centre_inc[IDX_W-1:0];
         if (pattern_mode == MODE_RAINBOW) begin
            if (frm_rem_sum >= {1'b0, SECTOR_SPAN}) begin
               off_rem_in = REM_W'(frm_rem_sum - {1'b0, SECTOR_SPAN});
               off_sec_in = (off_sec_ff == LAST_SECTOR) ? '0 : off_sec_ff + 3'd1;
            end else begin
               off_rem_in = frm_rem_sum[REM_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_ff  <= '0;
         off_sec_ff <= '0;
         off_rem_ff <= '0;
      end else begin
         centre_ff  <= centre_in;
         off_sec_ff <= off_sec_in;
         off_rem_ff <= off_rem_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      hsec_ff <= hsec_in;
      hrem_ff <= hrem_in;
   end

   // Stage 1: brightness from distance, saturation times remainder and times (60 - remainder).
   assign led_span = (idx_ff >= centre_ff) ? (idx_ff - centre_ff) : (centre_ff - idx_ff);

   always_ff @(posedge clock) begin
      s1_bright_ff <= (led_span <= MAX_DIST) ? bright_of(led_span[1:0]) : '0;
      s1_sec_ff    <= hsec_ff;
      s1_sq_ff     <= 14'(saturation) * 14'(hrem_ff);
      s1_st_ff     <= 14'(saturation) * 14'(SECTOR_SPAN - hrem_ff);
   end

   // Stage 2: divide by 60 through the reciprocal.
   assign prod_q = 29'(s1_sq_ff) * 29'(RECIP60);
   assign prod_t = 29'(s1_st_ff) * 29'(RECIP60);

   always_ff @(posedge clock) begin
      s2_bright_ff <= s1_bright_ff;
      s2_sec_ff    <= s1_sec_ff;
      s2_dq_ff     <= prod_q[RECIP60_SHR +: COLOR_W];
      s2_dt_ff     <= prod_t[RECIP60_SHR +: COLOR_W];
   end

   // Stage 3: brightness times (255 - x); 255 - x is the complement.
   always_ff @(posedge clock) begin
      s3_bright_ff <= s2_bright_ff;
      s3_sec_ff    <= s2_sec_ff;
      s3_mp_ff     <= 16'(s2_bright_ff) * 16'(COLOR_W'(~saturation));
      s3_mq_ff     <= 16'(s2_bright_ff) * 16'(COLOR_W'(~s2_dq_ff));
      s3_mt_ff     <= 16'(s2_bright_ff) * 16'(COLOR_W'(~s2_dt_ff));
   end

   // Stage 4: floor(x / 255) as (x + (x >> 8) + 1) >> 8, exact below 65535.
   assign sum_p = 17'(s3_mp_ff) + 17'(s3_mp_ff[15:8]) + 17'd1;
   assign sum_q = 17'(s3_mq_ff) + 17'(s3_mq_ff[15:8]) + 17'd1;
   assign sum_t = 17'(s3_mt_ff) + 17'(s3_mt_ff[15:8]) + 17'd1;

   always_ff @(posedge clock) begin
      s4_bright_ff <= s3_bright_ff;
      s4_sec_ff    <= s3_sec_ff;
      s4_p_ff      <= sum_p[15:8];
      s4_q_ff      <= sum_q[15:8];
      s4_t_ff      <= sum_t[15:8];
   end

   // Sector selection, with the gradient and grey cases.
   always_comb begin
      red_in   = s4_bright_ff;
      green_in = s4_p_ff;
      blue_in  = s4_q_ff;
      if (pattern_mode == MODE_GRADIENT) begin
         red_in   = '0;
         green_in = s4_bright_ff;
         blue_in  = '0;
      end else if (saturation == '0) begin
         red_in   = s4_bright_ff;
         green_in = s4_bright_ff;
         blue_in  = s4_bright_ff;
      end else begin
         case (s4_sec_ff)
            3'd0: begin
               red_in = s4_bright_ff; green_in = s4_t_ff;      blue_in = s4_p_ff;
            end
            3'd1: begin
               red_in = s4_q_ff;      green_in = s4_bright_ff; blue_in = s4_p_ff;
            end
            3'd2: begin
               red_in = s4_p_ff;      green_in = s4_bright_ff; blue_in = s4_t_ff;
            end
            3'd3: begin
               red_in = s4_p_ff;      green_in = s4_q_ff;      blue_in = s4_bright_ff;
            end
            3'd4: begin
               red_in = s4_t_ff;      green_in = s4_p_ff;      blue_in = s4_bright_ff;
            end
            default: begin
               red_in = s4_bright_ff; green_in = s4_p_ff;      blue_in = s4_q_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         led_index_ff <= idx_ff;
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         last_ff      <= stat.last;
      end
   end

   assign rsp_led_index = led_index_ff;
   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;
   assign rsp_last_led  = last_ff;

endmodule

[rtl/core/scrolling_led_pattern_generator_core.sv]
// ============================================================================
// scrolling_led_pattern_generator_core
// Frame-tick driven LED strip color generator with a rainbow chase mode and
// a green brightness gradient mode, configured over an APB-style port.
// ============================================================================
// Each transfer on the req channel is one frame tick; the block then sends one
// transfer per LED on the rsp channel, LED 0 first, with rsp_last_led set on the
// final LED of the frame. Each LED passes through a four-stage color pipeline
// that is not overlapped between LEDs: the next LED enters the pipeline only
// after the previous color is loaded into the output register, and a stall on
// the rsp side holds the frame. A new frame tick is taken as soon as the last
// color of the previous frame sits in the output register. Registers are at
// byte addresses 0 (led_count), 4 (pattern_mode) and 8 (saturation); change
// them only between frames. A led_count of zero behaves as one, and a count
// above MAX_LEDS behaves as MAX_LEDS. Brightness is 255 minus 35 per LED of
// distance from the moving centre and zero beyond three LEDs; the centre
// advances by one LED per frame, and in rainbow mode the base hue advances by
// five degrees per frame. Setting req_restart on a tick returns both to zero
// before that frame.
// ============================================================================
module scrolling_led_pattern_generator_core #(
   parameter int MAX_LEDS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // Frame tick channel.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_restart,
   // Color channel.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [slpg_pkg::IDX_W-1:0]       rsp_led_index,
   output logic [slpg_pkg::COLOR_W-1:0]     rsp_red,
   output logic [slpg_pkg::COLOR_W-1:0]     rsp_green,
   output logic [slpg_pkg::COLOR_W-1:0]     rsp_blue,
   output logic                             rsp_last_led,
   // Configuration port.
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [3:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import slpg_pkg::*;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEDS);

   logic [CNT_W-1:0]   led_count_ff;
   logic               pattern_mode_ff;
   logic [COLOR_W-1:0] saturation_ff;
   logic               csr_wr;
   logic [1:0]         csr_reg;
   logic [CNT_W-1:0]   led_cnt;

   slpg_cmd_type  cmd;
   slpg_stat_type stat;

   // The port never inserts wait states, so a write lands on the access cycle.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff    <= LED_COUNT_RST;
         pattern_mode_ff <= MODE_RAINBOW;
         saturation_ff   <= SATURATION_RST;
      end else if (csr_wr) begin
         case (csr_reg)
            REG_LED_COUNT:    led_count_ff    <= csr_pwdata[CNT_W-1:0];
            REG_PATTERN_MODE: pattern_mode_ff <= csr_pwdata[0];
            REG_SATURATION:   saturation_ff   <= csr_pwdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_LED_COUNT:    csr_prdata = 32'(led_count_ff);
         REG_PATTERN_MODE: csr_prdata = 32'(pattern_mode_ff);
         REG_SATURATION:   csr_prdata = 32'(saturation_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Effective LED count for the frame: at least one, at most MAX_LEDS.
   always_comb begin
      if (led_count_ff == '0) begin
         led_cnt = 7'd1;
      end else if (led_count_ff > MAX_CNT) begin
         led_cnt = MAX_CNT;
      end else begin
         led_cnt = led_count_ff;
      end
   end

   slpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   slpg_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_restart   (req_restart),
      .led_cnt       (led_cnt),
      .pattern_mode  (pattern_mode_ff),
      .saturation    (saturation_ff),
      .rsp_led_index (rsp_led_index),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_last_led  (rsp_last_led)
   );

endmodule
